### design/dgcg_pkg.sv
// ----------------------------------------------------------------------------
// dgcg_pkg
// Shared types and constants for the dual grid corner gather block.
// ----------------------------------------------------------------------------
package dgcg_pkg;

  // Fixed field widths of the ports
  localparam int CellW = 5;   // dual grid coordinate
  localparam int TileW = 8;   // tile code

  // One resolved dual cell request, handed from front to back
  typedef struct packed {
    logic [CellW-1:0] x;
    logic [CellW-1:0] y;
    logic [TileW-1:0] lt;        // tile (x-1, y-1), clamped
    logic [TileW-1:0] lb;        // tile (x-1, y),   clamped
    logic [TileW-1:0] rt;        // tile (x,   y-1), clamped
    logic [TileW-1:0] rb;        // tile (x,   y)
    logic             last_row;
    logic             last_col;
  } cell_req_t;

endpackage

### design/dgcg_front.sv
// ----------------------------------------------------------------------------
// dgcg_front
// Accepts tiles, tracks grid position, keeps the previous column and
// resolves the four clamped corners of the base dual cell of each tile.
// ----------------------------------------------------------------------------
module dgcg_front import dgcg_pkg::*; #(
  parameter int GridSize = 16,
  parameter int TileBits = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [TileW-1:0] tile_value_i,
  output logic             push_valid_o,
  input  logic             push_ready_i,
  output cell_req_t        push_data_o
);

  localparam int StoreW = (TileBits < TileW) ? TileBits : TileW;
  localparam int CntW   = (GridSize > 1) ? $clog2(GridSize) : 1;
  localparam logic [CntW-1:0] LastIdx = CntW'(GridSize - 1);

  // grid position and running neighbors
  logic [CntW-1:0]   col_q, row_q;
  logic [StoreW-1:0] above_q, diag_q;

  // stage A: accepted tile waiting for its column store read
  logic              a_valid_q;
  logic [StoreW-1:0] a_cur_q, a_above_q;
  logic [CntW-1:0]   a_x_q, a_y_q;
  logic              a_first_col_q, a_first_row_q, a_last_col_q, a_last_row_q;

  // column store, read-first
  logic [StoreW-1:0] mem_q [GridSize];
  logic [StoreW-1:0] rd_q;

  logic              accept, advance;
  logic [StoreW-1:0] cur, left, diag;
  logic              first_col, first_row, last_col, last_row;

  assign cur       = tile_value_i[StoreW-1:0];
  assign first_col = (col_q == '0);
  assign first_row = (row_q == '0);
  assign last_col  = (col_q == LastIdx);
  assign last_row  = (row_q == LastIdx);

  assign advance    = a_valid_q && push_ready_i;
  assign in_ready_o = !a_valid_q || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign left = a_first_col_q ? a_cur_q : rd_q;
  assign diag = a_first_row_q ? left : (a_first_col_q ? a_above_q : diag_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      above_q   <= '0;
      diag_q    <= '0;
      a_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        above_q <= cur;
        if (last_row) begin
          row_q <= '0;
          col_q <= last_col ? '0 : col_q + 1'b1;
        end else begin
          row_q <= row_q + 1'b1;
        end
      end
      if (advance) begin
        diag_q <= left;
      end
      if (accept) begin
        a_valid_q <= 1'b1;
      end else if (advance) begin
        a_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_cur_q       <= cur;
      a_above_q     <= first_row ? cur : above_q;
      a_x_q         <= col_q;
      a_y_q         <= row_q;
      a_first_col_q <= first_col;
      a_first_row_q <= first_row;
      a_last_col_q  <= last_col;
      a_last_row_q  <= last_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q         <= mem_q[row_q];
      mem_q[row_q] <= cur;
    end
  end

  assign push_valid_o         = a_valid_q;
  assign push_data_o.x        = CellW'(a_x_q);
  assign push_data_o.y        = CellW'(a_y_q);
  assign push_data_o.lt       = TileW'(diag);
  assign push_data_o.lb       = TileW'(left);
  assign push_data_o.rt       = TileW'(a_above_q);
  assign push_data_o.rb       = TileW'(a_cur_q);
  assign push_data_o.last_row = a_last_row_q;
  assign push_data_o.last_col = a_last_col_q;

endmodule

### design/dgcg_queue.sv
// ----------------------------------------------------------------------------
// dgcg_queue
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
module dgcg_queue import dgcg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  cell_req_t push_data_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output cell_req_t pop_data_o
);

  cell_req_t  ent_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = ent_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### design/dgcg_back.sv
// ----------------------------------------------------------------------------
// dgcg_back
// Expands each request into one to four dual cells, one per cycle while the
// output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module dgcg_back import dgcg_pkg::*; #(
  parameter int GridSize = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             pop_valid_i,
  output logic             pop_ready_o,
  input  cell_req_t        pop_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CellW-1:0] cell_x_o,
  output logic [CellW-1:0] cell_y_o,
  output logic [TileW-1:0] corner_left_top_o,
  output logic [TileW-1:0] corner_left_bottom_o,
  output logic [TileW-1:0] corner_right_top_o,
  output logic [TileW-1:0] corner_right_bottom_o,
  output logic             run_last_o,
  output logic             grid_done_o
);

  localparam logic [CellW-1:0] EdgeIdx = CellW'(GridSize);

  typedef enum logic [1:0] {
    PhBase,
    PhRowEnd,
    PhColEnd,
    PhCorner
  } phase_e;

  phase_e ph_q, ph_next;
  logic   ph_done;
  logic   load;

  // next cell of the same request, or done
  always_comb begin
    ph_next = PhBase;
    ph_done = 1'b1;
    unique case (ph_q)
      PhBase: begin
        if (pop_data_i.last_row) begin
          ph_next = PhRowEnd;
          ph_done = 1'b0;
        end else if (pop_data_i.last_col) begin
          ph_next = PhColEnd;
          ph_done = 1'b0;
        end
      end
      PhRowEnd: begin
        if (pop_data_i.last_col) begin
          ph_next = PhColEnd;
          ph_done = 1'b0;
        end
      end
      PhColEnd: begin
        if (pop_data_i.last_row) begin
          ph_next = PhCorner;
          ph_done = 1'b0;
        end
      end
      PhCorner: begin
        ph_done = 1'b1;
      end
      default: begin
        ph_done = 1'b1;
      end
    endcase
  end

  assign load        = pop_valid_i && (!out_valid_o || out_ready_i);
  assign pop_ready_o = load && ph_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q                  <= PhBase;
      out_valid_o           <= 1'b0;
      cell_x_o              <= '0;
      cell_y_o              <= '0;
      corner_left_top_o     <= '0;
      corner_left_bottom_o  <= '0;
      corner_right_top_o    <= '0;
      corner_right_bottom_o <= '0;
      run_last_o            <= 1'b0;
      grid_done_o           <= 1'b0;
    end else begin
      if (load) begin
        out_valid_o <= 1'b1;
        ph_q        <= ph_done ? PhBase : ph_next;
        run_last_o  <= ph_done;
        grid_done_o <= (ph_q == PhCorner);
        unique case (ph_q)
          PhBase: begin
            cell_x_o              <= pop_data_i.x;
            cell_y_o              <= pop_data_i.y;
            corner_left_top_o     <= pop_data_i.lt;
            corner_left_bottom_o  <= pop_data_i.lb;
            corner_right_top_o    <= pop_data_i.rt;
            corner_right_bottom_o <= pop_data_i.rb;
          end
          PhRowEnd: begin
            cell_x_o              <= pop_data_i.x;
            cell_y_o              <= EdgeIdx;
            corner_left_top_o     <= pop_data_i.lb;
            corner_left_bottom_o  <= pop_data_i.lb;
            corner_right_top_o    <= pop_data_i.rb;
            corner_right_bottom_o <= pop_data_i.rb;
          end
          PhColEnd: begin
            cell_x_o              <= EdgeIdx;
            cell_y_o              <= pop_data_i.y;
            corner_left_top_o     <= pop_data_i.rt;
            corner_left_bottom_o  <= pop_data_i.rb;
            corner_right_top_o    <= pop_data_i.rt;
            corner_right_bottom_o <= pop_data_i.rb;
          end
          PhCorner: begin
            cell_x_o              <= EdgeIdx;
            cell_y_o              <= EdgeIdx;
            corner_left_top_o     <= pop_data_i.rb;
            corner_left_bottom_o  <= pop_data_i.rb;
            corner_right_top_o    <= pop_data_i.rb;
            corner_right_bottom_o <= pop_data_i.rb;
          end
          default: begin
            cell_x_o <= pop_data_i.x;
          end
        endcase
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

endmodule

### design/dual_grid_corner_gather_core.sv
// ----------------------------------------------------------------------------
// dual_grid_corner_gather_core
// Turns a GRID_SIZE x GRID_SIZE tile grid into its dual grid of corner cells.
// ----------------------------------------------------------------------------
// Tiles enter one per request in column-major order (x outer, y inner) and
// each tile completes dual cell (x,y); the last tile of a column also gives
// (x,N), tiles of the last column also give (N,y), and the very last tile
// also gives (N,N), flagged by grid_done_o. Corners outside the grid are
// clamped, so border tiles repeat. run_last_o marks the final cell of each
// tile. The input takes one tile per cycle while in_ready_o is high; the
// output register delivers one cell per cycle while out_ready_i is high, so
// a tile yields one cell, or two to four cells on the grid edges. From input
// accept to the first valid cell, a request passes the column store read,
// the queue and the output register. The column store needs no clearing
// after reset: the first column never reads it. Only the low TILE_BITS bits
// of a tile code are kept (at most 8); after the last tile a new grid starts.
// ----------------------------------------------------------------------------
module dual_grid_corner_gather_core import dgcg_pkg::*; #(
  parameter int GRID_SIZE = 16,
  parameter int TILE_BITS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // tile input
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [TileW-1:0] tile_value_i,
  // dual cell output
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CellW-1:0] cell_x_o,
  output logic [CellW-1:0] cell_y_o,
  output logic [TileW-1:0] corner_left_top_o,
  output logic [TileW-1:0] corner_left_bottom_o,
  output logic [TileW-1:0] corner_right_top_o,
  output logic [TileW-1:0] corner_right_bottom_o,
  output logic             run_last_o,
  output logic             grid_done_o
);

  // front -> queue
  logic      push_valid, push_ready;
  cell_req_t push_data;
  // queue -> back
  logic      pop_valid, pop_ready;
  cell_req_t pop_data;

  // Front: position counters, column store, corner resolution
  dgcg_front #(
    .GridSize (GRID_SIZE),
    .TileBits (TILE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .tile_value_i (tile_value_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Short queue decouples the tile side from the cell side
  dgcg_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Back: one to four cells per request into the output register
  dgcg_back #(
    .GridSize (GRID_SIZE)
  ) u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .pop_valid_i           (pop_valid),
    .pop_ready_o           (pop_ready),
    .pop_data_i            (pop_data),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .cell_x_o              (cell_x_o),
    .cell_y_o              (cell_y_o),
    .corner_left_top_o     (corner_left_top_o),
    .corner_left_bottom_o  (corner_left_bottom_o),
    .corner_right_top_o    (corner_right_top_o),
    .corner_right_bottom_o (corner_right_bottom_o),
    .run_last_o            (run_last_o),
    .grid_done_o           (grid_done_o)
  );

endmodule

### design/dgcg_checker.sv
// ----------------------------------------------------------------------------
// dgcg_checker
// Port-level checks of the dual grid corner gather block.
// ----------------------------------------------------------------------------
module dgcg_checker import dgcg_pkg::*; #(
  parameter int GRID_SIZE = 16
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [CellW-1:0] cell_x_o,
  input logic [CellW-1:0] cell_y_o,
  input logic [TileW-1:0] corner_left_top_o,
  input logic             run_last_o,
  input logic             grid_done_o
);

  localparam logic [CellW-1:0] EdgeIdx = CellW'(GRID_SIZE);

  // stalled cell holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cell_x_o)
      && $stable(cell_y_o) && $stable(corner_left_top_o))
    else $error("output cell changed while stalled");

  // grid end is always the last cell of its tile
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && grid_done_o |-> run_last_o)
    else $error("grid_done without run_last");

  // grid end sits at the outer dual corner
  a_done_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && grid_done_o |-> (cell_x_o == EdgeIdx) && (cell_y_o == EdgeIdx))
    else $error("grid_done away from the outer corner");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid straight out of reset");

endmodule

bind dual_grid_corner_gather_core dgcg_checker #(
  .GRID_SIZE (GRID_SIZE)
) u_dgcg_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .cell_x_o          (cell_x_o),
  .cell_y_o          (cell_y_o),
  .corner_left_top_o (corner_left_top_o),
  .run_last_o        (run_last_o),
  .grid_done_o       (grid_done_o)
);
